[hdl/pts_pkg.sv]
// command and status codes shared by the scheduler, its checker and the testbench
`default_nettype none
package pts_pkg;

	localparam logic [2:0] CMD_INIT_TASK   = 3'd0;
	localparam logic [2:0] CMD_MAKE_READY  = 3'd1;
	localparam logic [2:0] CMD_RESUME      = 3'd2;
	localparam logic [2:0] CMD_START_TIMER = 3'd3;
	localparam logic [2:0] CMD_TICK        = 3'd4;
	localparam logic [2:0] CMD_DISPATCH    = 3'd5;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_ERR   = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;

endpackage
`default_nettype wire

[hdl/priority_task_scheduler_with_timers.sv]
// priority task scheduler: sorted ready queue, sorted timer queue, dispatch
// The block takes one command beat at a time and stalls its input until the result beat is
// built; the result waits in an output register, so the next command can be taken while it is
// still stalled. Both queues are circular buffers in memories with one write port and one
// registered read port, and sorted insertion walks from the tail one entry per step, moving
// entries back as it goes. A ready-queue insertion passes each entry it walks by through a
// queue read, a priority-table read and a compare and write, and writes the task where the
// walk stops. start_timer inserts into the timer queue by the same walk from the tail,
// make_ready may also requeue the current task, and tick does one ready-queue insertion
// for each expired timer whose task is not yet ready, while the ready queue has room. After
// reset the block is ready at once; no clearing pass is needed.
`default_nettype none
module priority_task_scheduler_with_timers #(
	parameter int MAX_TASKS = 16,
	parameter int PRIO_BITS = 8,
	parameter int TICK_BITS = 32
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [2:0]  command,
	input  wire logic [3:0]  task_id,
	input  wire logic [7:0]  priority_req,
	input  wire logic [31:0] timeout,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [3:0]       next_task,
	output logic             next_valid,
	output logic             should_yield,
	output logic [4:0]       expired_count,
	output logic [1:0]       status
);
	import pts_pkg::*;

	localparam int IW = $clog2(MAX_TASKS);
	localparam int CW = $clog2(MAX_TASKS + 1);
	localparam logic [IW-1:0] LAST = IW'(MAX_TASKS - 1);
	localparam logic [CW-1:0] FULL = CW'(MAX_TASKS);

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_PRD    = 4'd1;
	localparam logic [3:0] S_INS_A  = 4'd2;
	localparam logic [3:0] S_INS_B  = 4'd3;
	localparam logic [3:0] S_INS_C  = 4'd4;
	localparam logic [3:0] S_CUR    = 4'd5;
	localparam logic [3:0] S_CUR2   = 4'd6;
	localparam logic [3:0] S_TMR_A  = 4'd7;
	localparam logic [3:0] S_TMR_B  = 4'd8;
	localparam logic [3:0] S_TICK_A = 4'd9;
	localparam logic [3:0] S_TICK_B = 4'd10;
	localparam logic [3:0] S_DISP   = 4'd11;
	localparam logic [3:0] S_DONE   = 4'd12;

	function automatic logic [IW-1:0] nxt(input logic [IW-1:0] p);
		nxt = (p == LAST) ? '0 : p + IW'(1);
	endfunction

	function automatic logic [IW-1:0] prv(input logic [IW-1:0] p);
		prv = (p == '0) ? LAST : p - IW'(1);
	endfunction

	// memories
	logic [IW-1:0]        rq_mem [MAX_TASKS];
	logic [PRIO_BITS-1:0] prio_mem [MAX_TASKS];
	logic [IW-1:0]        tq_task_mem [MAX_TASKS];
	logic [TICK_BITS-1:0] tq_exp_mem [MAX_TASKS];

	logic [3:0]           state_q, ret_q;
	logic [MAX_TASKS-1:0] fl_rdy_q, fl_tmr_q, prio_vld_q;
	logic [CW-1:0]        rcnt_q, tcnt_q, k_q;
	logic [IW-1:0]        rh_q, rt_q, th_q, tt_q, wp_q, rp_q;
	logic [IW-1:0]        t_q, ins_task_q, cur_q;
	logic                 cur_vld_q;
	logic [PRIO_BITS-1:0] prio_t_q;
	logic [TICK_BITS-1:0] tick_q, left_q;

	logic [IW-1:0]        rq_rd_q, tq_rd_task_q;
	logic [TICK_BITS-1:0] tq_rd_exp_q;
	logic [PRIO_BITS-1:0] prio_rd_q;
	logic                 prio_rdv_q;

	logic [3:0] r_next_q;
	logic       r_val_q, r_yld_q;
	logic [4:0] r_exp_q;
	logic [1:0] r_st_q;

	logic                 accept, tin_ok, rq_full, tq_full;
	logic [IW-1:0]        ti;
	logic [PRIO_BITS-1:0] prio_eff;
	logic [TICK_BITS-1:0] lf;
	logic                 ge, le;

	logic                 rq_we, tq_we, prio_we;
	logic [IW-1:0]        rq_wd, rq_ra, tq_wt, tq_ra, prio_ra;
	logic [TICK_BITS-1:0] tq_wx;

	assign in_stall = (state_q != S_IDLE);
	assign accept   = in_valid && !in_stall;
	assign ti       = IW'(task_id);
	assign tin_ok   = ({28'd0, task_id} < 32'(MAX_TASKS));
	assign rq_full  = (rcnt_q == FULL);
	assign tq_full  = (tcnt_q == FULL);
	assign prio_eff = prio_rdv_q ? prio_rd_q : '0;
	assign lf       = (TICK_BITS'(timeout) == '0) ? TICK_BITS'(1) : TICK_BITS'(timeout);
	assign ge       = (prio_eff >= prio_t_q);
	assign le       = ((tq_rd_exp_q - tick_q) <= left_q);

	always_comb begin
		rq_we   = 1'b0;
		rq_wd   = rq_rd_q;
		tq_we   = 1'b0;
		tq_wt   = tq_rd_task_q;
		tq_wx   = tq_rd_exp_q;
		prio_we = accept && command == CMD_INIT_TASK && tin_ok && !fl_rdy_q[ti] && !rq_full;
		rq_ra   = (state_q == S_IDLE) ? rh_q : rp_q;
		tq_ra   = (state_q == S_TICK_A) ? th_q : rp_q;
		case (state_q)
			S_IDLE:   prio_ra = ti;
			S_CUR:    prio_ra = cur_q;
			S_TICK_B: prio_ra = tq_rd_task_q;
			default:  prio_ra = rq_rd_q;
		endcase
		case (state_q)
			S_INS_A: begin
				if (k_q == '0) begin
					rq_we = 1'b1;
					rq_wd = ins_task_q;
				end
			end
			S_INS_C: begin
				rq_we = 1'b1;
				if (ge) rq_wd = ins_task_q;
			end
			S_TMR_A: begin
				if (k_q == '0) begin
					tq_we = 1'b1;
					tq_wt = t_q;
					tq_wx = tick_q + left_q;
				end
			end
			S_TMR_B: begin
				tq_we = 1'b1;
				if (le) begin
					tq_wt = t_q;
					tq_wx = tick_q + left_q;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (rq_we) rq_mem[wp_q] <= rq_wd;
		if (state_q == S_IDLE || state_q == S_INS_A) rq_rd_q <= rq_mem[rq_ra];
	end

	always_ff @(posedge clk) begin
		if (tq_we) begin
			tq_task_mem[wp_q] <= tq_wt;
			tq_exp_mem[wp_q]  <= tq_wx;
		end
		if (state_q == S_TMR_A || state_q == S_TICK_A) begin
			tq_rd_task_q <= tq_task_mem[tq_ra];
			tq_rd_exp_q  <= tq_exp_mem[tq_ra];
		end
	end

	always_ff @(posedge clk) begin
		if (prio_we) prio_mem[ti] <= PRIO_BITS'(priority_req);
		prio_rd_q  <= prio_mem[prio_ra];
		prio_rdv_q <= prio_vld_q[prio_ra];
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			ret_q      <= S_DONE;
			fl_rdy_q   <= '0;
			fl_tmr_q   <= '0;
			prio_vld_q <= '0;
			rcnt_q     <= '0;
			tcnt_q     <= '0;
			rh_q       <= '0;
			rt_q       <= '0;
			th_q       <= '0;
			tt_q       <= '0;
			tick_q     <= '0;
			cur_vld_q  <= 1'b0;
			out_valid  <= 1'b0;
		end else begin
			if (!out_stall && state_q != S_DONE) out_valid <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						t_q      <= ti;
						r_next_q <= '0;
						r_val_q  <= 1'b0;
						r_yld_q  <= 1'b0;
						r_exp_q  <= '0;
						if (command <= CMD_START_TIMER && !tin_ok) begin
							r_st_q  <= ST_ERR;
							state_q <= S_DONE;
						end else begin
							case (command)
								CMD_INIT_TASK: begin
									if (fl_rdy_q[ti] || rq_full) begin
										r_st_q  <= ST_ERR;
										state_q <= S_DONE;
									end else begin
										r_st_q         <= ST_OK;
										prio_vld_q[ti] <= 1'b1;
										ins_task_q     <= ti;
										prio_t_q       <= PRIO_BITS'(priority_req);
										ret_q          <= S_DONE;
										k_q            <= rcnt_q;
										wp_q           <= rt_q;
										rp_q           <= prv(rt_q);
										state_q        <= S_INS_A;
									end
								end
								CMD_MAKE_READY, CMD_RESUME: begin
									if (fl_rdy_q[ti] || rq_full) begin
										r_st_q  <= ST_ERR;
										state_q <= S_DONE;
									end else begin
										r_st_q     <= ST_OK;
										ins_task_q <= ti;
										ret_q      <= (command == CMD_MAKE_READY) ? S_CUR : S_DONE;
										state_q    <= S_PRD;
									end
								end
								CMD_START_TIMER: begin
									if (fl_tmr_q[ti] || tq_full) begin
										r_st_q  <= ST_ERR;
										state_q <= S_DONE;
									end else begin
										r_st_q  <= ST_OK;
										left_q  <= lf;
										k_q     <= tcnt_q;
										wp_q    <= tt_q;
										rp_q    <= prv(tt_q);
										state_q <= S_TMR_A;
									end
								end
								CMD_TICK: begin
									r_st_q  <= ST_OK;
									tick_q  <= tick_q + TICK_BITS'(1);
									state_q <= S_TICK_A;
								end
								CMD_DISPATCH: begin
									if (rcnt_q == '0) begin
										r_st_q    <= ST_EMPTY;
										cur_vld_q <= 1'b0;
										state_q   <= S_DONE;
									end else begin
										r_st_q  <= ST_OK;
										state_q <= S_DISP;
									end
								end
								default: begin
									r_st_q  <= ST_OK;
									state_q <= S_DONE;
								end
							endcase
						end
					end
				end
				S_PRD: begin
					prio_t_q <= prio_eff;
					k_q      <= rcnt_q;
					wp_q     <= rt_q;
					rp_q     <= prv(rt_q);
					state_q  <= S_INS_A;
				end
				S_INS_A: begin
					if (k_q == '0) begin
						rcnt_q               <= rcnt_q + CW'(1);
						rt_q                 <= nxt(rt_q);
						fl_rdy_q[ins_task_q] <= 1'b1;
						state_q              <= ret_q;
					end else begin
						state_q <= S_INS_B;
					end
				end
				S_INS_B: state_q <= S_INS_C;
				S_INS_C: begin
					// stop behind the last entry of equal or higher priority
					if (ge) begin
						rcnt_q               <= rcnt_q + CW'(1);
						rt_q                 <= nxt(rt_q);
						fl_rdy_q[ins_task_q] <= 1'b1;
						state_q              <= ret_q;
					end else begin
						wp_q    <= rp_q;
						rp_q    <= prv(rp_q);
						k_q     <= k_q - CW'(1);
						state_q <= S_INS_A;
					end
				end
				S_CUR: state_q <= cur_vld_q ? S_CUR2 : S_DONE;
				S_CUR2: begin
					if (prio_t_q > prio_eff) begin
						r_yld_q <= 1'b1;
						if (!fl_rdy_q[cur_q] && !rq_full) begin
							ins_task_q <= cur_q;
							prio_t_q   <= prio_eff;
							ret_q      <= S_DONE;
							k_q        <= rcnt_q;
							wp_q       <= rt_q;
							rp_q       <= prv(rt_q);
							state_q    <= S_INS_A;
						end else begin
							state_q <= S_DONE;
						end
					end else begin
						state_q <= S_DONE;
					end
				end
				S_TMR_A: begin
					if (k_q == '0) begin
						tcnt_q        <= tcnt_q + CW'(1);
						tt_q          <= nxt(tt_q);
						fl_tmr_q[t_q] <= 1'b1;
						state_q       <= S_DONE;
					end else begin
						state_q <= S_TMR_B;
					end
				end
				S_TMR_B: begin
					if (le) begin
						tcnt_q        <= tcnt_q + CW'(1);
						tt_q          <= nxt(tt_q);
						fl_tmr_q[t_q] <= 1'b1;
						state_q       <= S_DONE;
					end else begin
						wp_q    <= rp_q;
						rp_q    <= prv(rp_q);
						k_q     <= k_q - CW'(1);
						state_q <= S_TMR_A;
					end
				end
				S_TICK_A: state_q <= (tcnt_q == '0) ? S_DONE : S_TICK_B;
				S_TICK_B: begin
					if (tq_rd_exp_q == tick_q) begin
						th_q                   <= nxt(th_q);
						tcnt_q                 <= tcnt_q - CW'(1);
						fl_tmr_q[tq_rd_task_q] <= 1'b0;
						r_exp_q                <= r_exp_q + 5'd1;
						if (fl_rdy_q[tq_rd_task_q] || rq_full) begin
							r_st_q  <= ST_ERR;
							state_q <= S_TICK_A;
						end else begin
							ins_task_q <= tq_rd_task_q;
							ret_q      <= S_TICK_A;
							state_q    <= S_PRD;
						end
					end else begin
						state_q <= S_DONE;
					end
				end
				S_DISP: begin
					r_next_q          <= 4'(rq_rd_q);
					r_val_q           <= 1'b1;
					rh_q              <= nxt(rh_q);
					rcnt_q            <= rcnt_q - CW'(1);
					fl_rdy_q[rq_rd_q] <= 1'b0;
					cur_q             <= rq_rd_q;
					cur_vld_q         <= 1'b1;
					state_q           <= S_DONE;
				end
				S_DONE: begin
					if (!out_valid || !out_stall) begin
						out_valid <= 1'b1;
						state_q   <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// result beat register
	always_ff @(posedge clk) begin
		if (state_q == S_DONE && (!out_valid || !out_stall)) begin
			next_task     <= r_next_q;
			next_valid    <= r_val_q;
			should_yield  <= r_yld_q;
			expired_count <= r_exp_q;
			status        <= r_st_q;
		end
	end

endmodule
`default_nettype wire

[hdl/pts_check.sv]
// port-level checker for the scheduler, bound to the scheduler module
`default_nettype none
module pts_check (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_stall,
	input wire logic [2:0]  command,
	input wire logic [3:0]  task_id,
	input wire logic [7:0]  priority_req,
	input wire logic [31:0] timeout,
	input wire logic        out_valid,
	input wire logic        out_stall,
	input wire logic [3:0]  next_task,
	input wire logic        next_valid,
	input wire logic        should_yield,
	input wire logic [4:0]  expired_count,
	input wire logic [1:0]  status
);
	import pts_pkg::*;

	// an accepted command always leaves the input stalled, so two beats are never taken in a row
	a_busy_after_beat: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken twice in a row");

	a_dispatch_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && next_valid |-> status == ST_OK && !should_yield && expired_count == 5'd0)
		else $error("dispatch beat with other fields set");

	a_yield_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && should_yield |-> status == ST_OK && expired_count == 5'd0)
		else $error("yield with error or expiry");

	a_empty_no_task: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_EMPTY |-> !next_valid && next_task == 4'd0)
		else $error("empty status with a task");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(next_task) && $stable(status)
		&& $stable(expired_count))
		else $error("stalled result beat changed");

endmodule

bind priority_task_scheduler_with_timers pts_check u_pts_check (.*);
`default_nettype wire

[dv/tb_priority_task_scheduler_with_timers.sv]
// self-checking testbench for the priority task scheduler with timers
`default_nettype none
module tb_priority_task_scheduler_with_timers;
	timeunit 1ns;
	timeprecision 1ps;
	import pts_pkg::*;

	localparam int NTASK = 16;
	localparam int WATCHDOG_LIMIT = 20000;

	typedef struct packed {
		logic [3:0] next_task;
		logic       next_valid;
		logic       should_yield;
		logic [4:0] expired_count;
		logic [1:0] status;
	} sched_result_t;

	logic clk, arst_n;
	logic in_valid, in_stall, out_valid, out_stall;
	logic [2:0] command;
	logic [3:0] task_id;
	logic [7:0] priority_req;
	logic [31:0] timeout;
	logic [3:0] next_task;
	logic next_valid, should_yield;
	logic [4:0] expired_count;
	logic [1:0] status;

	priority_task_scheduler_with_timers dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.command(command), .task_id(task_id), .priority_req(priority_req), .timeout(timeout),
		.out_valid(out_valid), .out_stall(out_stall),
		.next_task(next_task), .next_valid(next_valid), .should_yield(should_yield),
		.expired_count(expired_count), .status(status)
	);

	// scheduler shadow state
	logic [7:0]  prio_of [NTASK];
	logic [3:0]  ready_ids[$];
	logic [3:0]  timer_ids[$];
	logic [31:0] timer_due[$];
	logic [31:0] now;
	logic        have_current;
	logic [3:0]  current_id;
	bit          is_ready [NTASK];
	bit          is_timing [NTASK];

	sched_result_t pending_results[$];
	int error_count;
	int send_idle_pct, recv_stall_pct;
	bit hold_off;
	int quiet_cycles;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic bit push_ready(logic [3:0] t);
		int pos;
		if (is_ready[t] || ready_ids.size() >= NTASK) return 1'b0;
		pos = 0;
		while (pos < ready_ids.size() && prio_of[ready_ids[pos]] >= prio_of[t]) pos++;
		ready_ids.insert(pos, t);
		is_ready[t] = 1'b1;
		return 1'b1;
	endfunction

	function automatic bit arm_timer(logic [3:0] t, logic [31:0] ticks);
		int pos;
		logic [31:0] left;
		if (is_timing[t] || timer_ids.size() >= NTASK) return 1'b0;
		left = (ticks == 0) ? 32'd1 : ticks;
		pos = 0;
		while (pos < timer_ids.size() && (timer_due[pos] - now) <= left) pos++;
		timer_ids.insert(pos, t);
		timer_due.insert(pos, now + left);
		is_timing[t] = 1'b1;
		return 1'b1;
	endfunction

	function automatic sched_result_t schedule_step(logic [2:0] cmd, logic [3:0] t,
			logic [7:0] pr, logic [31:0] tmo);
		sched_result_t r;
		logic [3:0] due;
		r = '0;
		r.status = ST_OK;
		case (cmd)
			CMD_INIT_TASK: begin
				if (is_ready[t] || ready_ids.size() >= NTASK) r.status = ST_ERR;
				else begin
					prio_of[t] = pr;
					void'(push_ready(t));
				end
			end
			CMD_MAKE_READY: begin
				if (!push_ready(t)) r.status = ST_ERR;
				else if (have_current && prio_of[t] > prio_of[current_id]) begin
					r.should_yield = 1'b1;
					void'(push_ready(current_id));
				end
			end
			CMD_RESUME: if (!push_ready(t)) r.status = ST_ERR;
			CMD_START_TIMER: if (!arm_timer(t, tmo)) r.status = ST_ERR;
			CMD_TICK: begin
				now = now + 1;
				while (timer_ids.size() > 0 && timer_due[0] == now) begin
					due = timer_ids.pop_front();
					void'(timer_due.pop_front());
					is_timing[due] = 1'b0;
					r.expired_count++;
					if (!push_ready(due)) r.status = ST_ERR;
				end
			end
			CMD_DISPATCH: begin
				if (ready_ids.size() == 0) begin
					r.status = ST_EMPTY;
					have_current = 1'b0;
				end else begin
					r.next_task = ready_ids.pop_front();
					is_ready[r.next_task] = 1'b0;
					current_id = r.next_task;
					have_current = 1'b1;
					r.next_valid = 1'b1;
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
		error_count++;
	endtask

	// one command beat; prediction at acceptance, valid drops when the sender idles
	task automatic send_command(logic [2:0] cmd, logic [3:0] t, logic [7:0] pr, logic [31:0] tmo);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		command <= cmd;
		task_id <= t;
		priority_req <= pr;
		timeout <= tmo;
		do @(posedge clk); while (in_stall);
		pending_results.push_back(schedule_step(cmd, t, pr, tmo));
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			out_stall <= hold_off || ($urandom_range(99) < recv_stall_pct);
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
			else quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles > WATCHDOG_LIMIT) begin
				$display("DONE: errors detected");
				$finish;
			end
		end
	end

	// result checker
	always @(posedge clk) begin
		sched_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				$display("unexpected result beat at %0t", $realtime);
				error_count++;
			end else begin
				want = pending_results.pop_front();
				if (next_task !== want.next_task)
					report_mismatch("next_task", next_task, want.next_task);
				if (next_valid !== want.next_valid)
					report_mismatch("next_valid", next_valid, want.next_valid);
				if (should_yield !== want.should_yield)
					report_mismatch("should_yield", should_yield, want.should_yield);
				if (expired_count !== want.expired_count)
					report_mismatch("expired_count", expired_count, want.expired_count);
				if (status !== want.status)
					report_mismatch("status", status, want.status);
			end
		end
	end

	task automatic test_directed();
		send_command(CMD_DISPATCH, 4'd0, 8'd0, 32'd0);
		send_command(CMD_INIT_TASK, 4'd0, 8'd0, 32'd0);
		send_command(CMD_INIT_TASK, 4'd15, 8'd255, 32'hFFFF_FFFF);
		send_command(CMD_INIT_TASK, 4'd5, 8'd255, 32'd0);
		send_command(CMD_INIT_TASK, 4'd5, 8'd7, 32'd0);      // duplicate
		send_command(CMD_RESUME, 4'd0, 8'd0, 32'd0);         // duplicate
		send_command(CMD_DISPATCH, 4'd0, 8'd0, 32'd0);
		send_command(CMD_MAKE_READY, 4'd15, 8'd0, 32'd0);    // equal prio, no yield
		send_command(CMD_INIT_TASK, 4'd9, 8'd3, 32'd0);
		send_command(CMD_DISPATCH, 4'd0, 8'd0, 32'd0);
		send_command(CMD_DISPATCH, 4'd0, 8'd0, 32'd0);
		send_command(CMD_DISPATCH, 4'd0, 8'd0, 32'd0);       // current is low prio
		send_command(CMD_MAKE_READY, 4'd15, 8'd0, 32'd0);    // yield, current re-enqueued
		send_command(CMD_START_TIMER, 4'd3, 8'd0, 32'd0);    // zero timeout
		send_command(CMD_START_TIMER, 4'd15, 8'd0, 32'd1);   // task already ready
		send_command(CMD_START_TIMER, 4'd3, 8'd0, 32'd5);    // duplicate timer
		send_command(CMD_START_TIMER, 4'd7, 8'd0, 32'hFFFF_FFFF);
		send_command(CMD_TICK, 4'd0, 8'd0, 32'd0);
		send_command(CMD_TICK, 4'd0, 8'd0, 32'd0);
		send_command(3'd6, 4'd10, 8'hAA, 32'h5555_5555);
		send_command(3'd7, 4'd5, 8'h55, 32'hAAAA_AAAA);
		for (int i = 0; i < 4; i++) send_command(CMD_DISPATCH, 4'd0, 8'd0, 32'd0);
	endtask

	task automatic drain();
		int guard;
		guard = 0;
		in_valid <= 1'b0;
		while (pending_results.size() != 0 && guard < 200000) begin
			@(posedge clk);
			guard++;
		end
		repeat (150) @(posedge clk);
	endtask

	task automatic test_random(int count);
		logic [2:0] cmd;
		logic [31:0] tmo;
		int pick;
		for (int i = 0; i < count; i++) begin
			pick = $urandom_range(99);
			if (pick < 12) cmd = CMD_INIT_TASK;
			else if (pick < 24) cmd = CMD_MAKE_READY;
			else if (pick < 32) cmd = CMD_RESUME;
			else if (pick < 50) cmd = CMD_START_TIMER;
			else if (pick < 75) cmd = CMD_TICK;
			else if (pick < 97) cmd = CMD_DISPATCH;
			else cmd = 3'($urandom_range(6, 7));
			case ($urandom_range(9))
				0: tmo = $urandom;
				1: tmo = 32'hFFFF_FFFF - $urandom_range(3);
				2: tmo = 32'd0;
				default: tmo = $urandom_range(1, 12);
			endcase
			send_command(cmd, 4'($urandom_range(15)), 8'($urandom), tmo);
		end
	endtask

	// receiver holds off while commands keep coming, so the block backs up
	task automatic test_backpressure();
		fork
			begin
				hold_off = 1'b1;
				repeat (400) @(posedge clk);
				hold_off = 1'b0;
			end
			test_random(40);
		join
	endtask

	initial begin
		error_count = 0;
		quiet_cycles = 0;
		hold_off = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		out_stall = 1'b0;
		command = '0;
		task_id = '0;
		priority_req = '0;
		timeout = '0;
		now = '0;
		have_current = 1'b0;
		current_id = '0;
		for (int i = 0; i < NTASK; i++) begin
			prio_of[i] = '0;
			is_ready[i] = 1'b0;
			is_timing[i] = 1'b0;
		end
		send_idle_pct = 6;
		recv_stall_pct = 77;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(600);
		send_idle_pct = 77;
		recv_stall_pct = 6;
		test_random(600);
		send_idle_pct = 0;
		recv_stall_pct = 0;
		test_backpressure();
		test_random(680);
		drain();
		if (error_count == 0 && pending_results.size() == 0) $display("DONE: 0 errors");
		else $display("DONE: errors detected");
		$finish;
	end
endmodule
`default_nettype wire

[sim.f]
hdl/pts_pkg.sv
hdl/priority_task_scheduler_with_timers.sv
hdl/pts_check.sv
dv/tb_priority_task_scheduler_with_timers.sv
